// File: sv/assert_macros.svh
// Assertion macros shared by the RTL of the keyed-removal deque.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define AST_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that forces a consequence in the next.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dkr_pkg.sv
// Package for the keyed-removal deque: command and status codes, sequencer
// states, cell control struct and fixed field widths. No dependencies.
package dkr_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned PAY_W     = 64;
  localparam int unsigned OCC_W     = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_TAKE   = 2'd2,
    CMD_REMOVE = 2'd3
  } dkr_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } dkr_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } dkr_state_t;

  // Per-cell load selection for the apply cycle
  typedef struct packed {
    logic load_new;
    logic from_prev;
    logic from_next;
  } dkr_cell_ctl_t;

endpackage

// File: sv/deque_with_keyed_removal.sv
// Top level of the bounded deque with removal by key: row of dkr_cell,
// first-match scan in dkr_scan, sequencer and result register.
// Depends on dkr_pkg, dkr_cell, dkr_scan and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                 | tuser
//  in_     | in  | entry_key[63:0], entry_payload     | command
//  out_    | out | out_key, out_payload, occupancy    | status
//
// Each request passes through accept (cells compare the key), scan
// (first-match mask is registered) and apply (row shifts, result loads).
// The apply cycle waits while the result register still holds an untaken
// result; a new request is accepted once the sequencer is back in idle.
// Reset (rst_n low, synchronous) empties the deque; stored data is not cleared.
`include "assert_macros.svh"

module deque_with_keyed_removal import dkr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned KEY_WIDTH   = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // entry_key[63:0], entry_payload[127:64]
  input  logic [1:0]   in_tuser,   // command[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // out_key[63:0], out_payload[127:64], occupancy[135:128]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  dkr_state_t state_r, state_nxt;
  dkr_cmd_t   cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [PAY_W-1:0]     pay_r;
  logic [CW-1:0]        count_r, count_nxt;

  logic in_accept, apply;
  logic full, empty, found;
  logic app_ok, ins_ok, take_ok, rem_ok;
  logic [KEY_WIDTH-1:0] in_key;

  logic [KEY_WIDTH-1:0] cell_key [QUEUE_DEPTH];
  logic [PAY_W-1:0]     cell_pay [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match, ge, occ, sel;
  dkr_cell_ctl_t ctl [QUEUE_DEPTH];

  logic [KEY_WIDTH-1:0] rkey;
  logic [PAY_W-1:0]     rpay;
  dkr_status_t          status;

  logic                 out_valid_r, out_valid_nxt;
  logic [KEY_WIDTH-1:0] out_key_r;
  logic [PAY_W-1:0]     out_pay_r;
  logic [OCC_W-1:0]     out_occ_r;
  dkr_status_t          out_sts_r;

  assign in_key    = in_tdata[KEY_WIDTH-1:0];
  assign in_accept = in_tvalid && in_tready;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = ST_SCAN;
      ST_SCAN:  state_nxt = ST_APPLY;
      ST_APPLY: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_tready = 1'b0;
    apply     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_SCAN:  ;
      ST_APPLY: apply = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= dkr_cmd_t'(in_tuser);
      key_r <= in_key;
      pay_r <= in_tdata[KEY_PORT_W +: PAY_W];
    end
  end

  assign full  = (count_r == DEPTH_C);
  assign empty = (count_r == '0);
  assign found = ge[QUEUE_DEPTH-1];

  assign app_ok  = (cmd_r == CMD_APPEND) && !full;
  assign ins_ok  = (cmd_r == CMD_INSERT) && !full;
  assign take_ok = (cmd_r == CMD_TAKE)   && !empty;
  assign rem_ok  = (cmd_r == CMD_REMOVE) && found;

  always_comb begin
    count_nxt = count_r;
    if (apply) begin
      priority if (app_ok || ins_ok) count_nxt = count_r + 1'b1;
      else if (take_ok || rem_ok)    count_nxt = count_r - 1'b1;
      else                           count_nxt = count_r;
    end
  end

  always_comb begin
    unique case (cmd_r)
      CMD_APPEND, CMD_INSERT: status = full ? STS_FULL : STS_OK;
      CMD_TAKE:               status = empty ? STS_EMPTY : STS_OK;
      CMD_REMOVE:             status = found ? STS_OK : STS_NOT_FOUND;
      default:                status = STS_OK;
    endcase
  end

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_row
    logic [KEY_WIDTH-1:0] prev_k, next_k;
    logic [PAY_W-1:0]     prev_p, next_p;

    if (i == 0) begin : g_first
      assign prev_k = key_r;
      assign prev_p = pay_r;
      assign sel[i] = (cmd_r == CMD_REMOVE) ? ge[i] : 1'b1;
    end else begin : g_rest
      assign prev_k = cell_key[i-1];
      assign prev_p = cell_pay[i-1];
      assign sel[i] = (cmd_r == CMD_REMOVE) && ge[i] && !ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_k = cell_key[i];
      assign next_p = cell_pay[i];
    end else begin : g_inner
      assign next_k = cell_key[i+1];
      assign next_p = cell_pay[i+1];
    end

    assign occ[i] = (CW'(i) < count_r);
    assign ctl[i].load_new  = apply && ((app_ok && (count_r == CW'(i)))
                                        || (ins_ok && (i == 0)));
    assign ctl[i].from_prev = apply && ins_ok && (i != 0);
    assign ctl[i].from_next = apply && (take_ok || (rem_ok && ge[i]))
                              && (i != QUEUE_DEPTH - 1);

    dkr_cell #(.KW(KEY_WIDTH)) u_cell (
      .clk      (clk),
      .match_en (in_accept),
      .cmp_key  (in_key),
      .occ      (occ[i]),
      .ctl      (ctl[i]),
      .new_key  (key_r),
      .new_pay  (pay_r),
      .prev_key (prev_k),
      .prev_pay (prev_p),
      .next_key (next_k),
      .next_pay (next_p),
      .key_o    (cell_key[i]),
      .pay_o    (cell_pay[i]),
      .match_o  (match[i])
    );
  end

  dkr_scan #(.DEPTH(QUEUE_DEPTH)) u_scan (
    .clk   (clk),
    .match (match),
    .ge_o  (ge)
  );

  // picked entry: front cell for take, first match for remove
  always_comb begin
    rkey = '0;
    rpay = '0;
    if (take_ok || rem_ok) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        rkey = rkey | (cell_key[i] & {KEY_WIDTH{sel[i]}});
        rpay = rpay | (cell_pay[i] & {PAY_W{sel[i]}});
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (apply)      out_valid_nxt = 1'b1;
    else if (out_tready)     out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_key_r <= rkey;
      out_pay_r <= rpay;
      out_occ_r <= OCC_W'(count_nxt);
      out_sts_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_occ_r, out_pay_r, KEY_PORT_W'(out_key_r)};
  assign out_tuser  = out_sts_r;

  `AST_ALWAYS(a_count_bound, count_r <= DEPTH_C, "entry count beyond depth")
  `AST_NEXT(a_grow, apply && (app_ok || ins_ok), count_r == CW'($past(count_r) + 1'b1), "count did not grow on insert")
  `AST_NEXT(a_rem_key, apply && rem_ok, out_tdata[KEY_WIDTH-1:0] == key_r, "removed key differs from search key")
  `AST_NEXT(a_busy, in_accept, !in_tready, "request accepted while busy")

endmodule

// File: sv/dkr_cell.sv
// One storage cell of the deque row: key, payload and a key-match flag.
// Depends on dkr_pkg for the cell control struct.
module dkr_cell import dkr_pkg::*; #(
  parameter int unsigned KW = 64
) (
  input  logic          clk,
  input  logic          match_en,
  input  logic [KW-1:0] cmp_key,
  input  logic          occ,
  input  dkr_cell_ctl_t ctl,
  input  logic [KW-1:0] new_key,
  input  logic [PAY_W-1:0] new_pay,
  input  logic [KW-1:0] prev_key,
  input  logic [PAY_W-1:0] prev_pay,
  input  logic [KW-1:0] next_key,
  input  logic [PAY_W-1:0] next_pay,
  output logic [KW-1:0] key_o,
  output logic [PAY_W-1:0] pay_o,
  output logic          match_o
);

  logic [KW-1:0]    key_r, key_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic             match_r, match_nxt;

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    priority if (ctl.load_new) begin
      key_nxt = new_key;
      pay_nxt = new_pay;
    end else if (ctl.from_prev) begin
      key_nxt = prev_key;
      pay_nxt = prev_pay;
    end else if (ctl.from_next) begin
      key_nxt = next_key;
      pay_nxt = next_pay;
    end else begin
      key_nxt = key_r;
      pay_nxt = pay_r;
    end
  end

  assign match_nxt = match_en ? (occ && (key_r == cmp_key)) : match_r;

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    pay_r   <= pay_nxt;
    match_r <= match_nxt;
  end

  assign key_o   = key_r;
  assign pay_o   = pay_r;
  assign match_o = match_r;

endmodule

// File: sv/dkr_scan.sv
// Turns the row's match flags into a registered mask of all cells at or
// behind the first match. No package dependencies.
module dkr_scan #(
  parameter int unsigned DEPTH = 128
) (
  input  logic             clk,
  input  logic [DEPTH-1:0] match,
  output logic [DEPTH-1:0] ge_o
);

  logic [DEPTH-1:0] ge_r, ge_nxt;

  // m | -m sets every bit from the lowest set bit upward; zero if no match
  assign ge_nxt = match | (~match + {{(DEPTH-1){1'b0}}, 1'b1});

  always_ff @(posedge clk) begin
    ge_r <= ge_nxt;
  end

  assign ge_o = ge_r;

endmodule
